// File: hw/rtl/multiset_count_table_unit_macros.svh
// assertion macros for the multiset count table unit
// no dependencies; included by the top level only
`ifndef MULTISET_COUNT_TABLE_UNIT_MACROS_SVH
`define MULTISET_COUNT_TABLE_UNIT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, disabled during reset
`define MCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/mct_pkg.sv
// shared types and constants for the multiset count table unit
// no dependencies; imported by every module of the block
package mct_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int REQ_W   = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
    localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] occurrences;
        logic [COUNT_W-1:0] entry_total;
        logic               is_empty;
        logic               rejected_full;
    } t_res;

endpackage

// File: hw/rtl/multiset_count_table_unit.sv
// top level of the multiset count table unit: sequencer and table ram
// depends on mct_pkg, mct_ram and multiset_count_table_unit_macros.svh
//
// channel   direction  handshake              payload
// request   in         start high, busy low   i_req  (t_req)
// result    out        o_done, one cycle      o_res  (t_res)
//
// a search, count or add scans every stored copy before the result strobe; a
// remove that finds the value also shifts down the entries after the removed
// copy at idx. both the scan and the shift are set by the single read port of
// the table ram, one entry per cycle.
// reset empties the table at once; stored entries are never cleared, only the
// fill count. results are not back-pressured: o_done marks one cycle.
`include "multiset_count_table_unit_macros.svh"

module multiset_count_table_unit
    import mct_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_res o_res
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = VALUE_W + CW;

    localparam logic [CW-1:0] CAP_N = CW'(CAPACITY);
    localparam logic [CW-1:0] C_ONE = CW'(1);
    localparam logic [IW-1:0] I_ONE = IW'(1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    // control and tracking registers
    logic [1:0]         r_state,     n_state;
    logic [CW-1:0]      r_total,     n_total;
    logic [CW-1:0]      r_ptr,       n_ptr;
    logic               r_pend,      n_pend;
    logic [IW-1:0]      r_pend_idx,  n_pend_idx;
    logic [REQ_W-1:0]   r_req_type,  n_req_type;
    logic [VALUE_W-1:0] r_value,     n_value;
    logic               r_found,     n_found;
    logic               r_multi,     n_multi;
    logic [CW-1:0]      r_first_cnt, n_first_cnt;
    logic [CW-1:0]      r_last_cnt,  n_last_cnt;
    logic [IW-1:0]      r_idx,       n_idx;
    logic               r_done,      n_done;
    t_res               r_res,       n_res;

    // ram port signals
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [MW-1:0]      ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [MW-1:0]      ram_rdata;

    logic [VALUE_W-1:0] rd_value;
    logic [CW-1:0]      rd_count;
    logic               match;
    logic               issue;
    logic               walk_end;
    logic               add_ok;
    logic               is_rem;
    logic               fin;
    logic [CW-1:0]      occ_sel;

    // table ram: {count, value} per stored copy
    mct_ram #(
        .WIDTH (MW),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_value = ram_rdata[VALUE_W-1:0];
    assign rd_count = ram_rdata[MW-1:VALUE_W];
    assign match    = r_pend && (rd_value == r_value);
    assign issue    = (r_ptr != r_total);
    assign walk_end = (r_ptr == r_total) && !r_pend;
    assign add_ok   = (r_req_type == REQ_ADD) && (r_total != CAP_N);
    assign is_rem   = (r_req_type == REQ_REMOVE);

    // count of the first matching copy after the transaction
    always_comb begin
        if (add_ok) begin
            occ_sel = r_found ? (r_first_cnt + C_ONE) : C_ONE;
        end else if (is_rem) begin
            occ_sel = r_multi ? (r_first_cnt - C_ONE) : '0;
        end else begin
            occ_sel = r_found ? r_first_cnt : '0;
        end
    end

    // sequencer: scan reads entry i while entry i-1 is written back, and the
    // shift reads entry i+1 while writing entry i-1, so no address is ever
    // read and written in the same cycle and no forwarding is needed
    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_ptr       = r_ptr;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_req_type  = r_req_type;
        n_value     = r_value;
        n_found     = r_found;
        n_multi     = r_multi;
        n_first_cnt = r_first_cnt;
        n_last_cnt  = r_last_cnt;
        n_idx       = r_idx;
        n_done      = 1'b0;
        n_res       = r_res;
        fin         = 1'b0;

        ram_re    = 1'b0;
        ram_raddr = r_ptr[IW-1:0];
        ram_we    = 1'b0;
        ram_waddr = r_pend_idx;
        ram_wdata = ram_rdata;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req_type  = i_req.req_type;
                    n_value     = i_req.value;
                    n_ptr       = '0;
                    n_found     = 1'b0;
                    n_multi     = 1'b0;
                    n_first_cnt = '0;
                    n_last_cnt  = '0;
                    n_idx       = '0;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue the next read
                if (issue) begin
                    ram_re     = 1'b1;
                    n_ptr      = r_ptr + C_ONE;
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr[IW-1:0];
                end
                // compare returned entry and update its count
                if (match) begin
                    if (r_found) begin
                        n_multi = 1'b1;
                    end else begin
                        n_first_cnt = rd_count;
                    end
                    n_found    = 1'b1;
                    n_last_cnt = rd_count;
                    n_idx      = r_pend_idx;
                    if (add_ok) begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_count + C_ONE, rd_value};
                    end else if (is_rem) begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_count - C_ONE, rd_value};
                    end
                end
                // end of scan
                if (walk_end) begin
                    if (add_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_total[IW-1:0];
                        ram_wdata = {r_last_cnt + C_ONE, r_value};
                        n_total   = r_total + C_ONE;
                        fin       = 1'b1;
                    end else if (is_rem && r_found) begin
                        n_ptr   = CW'(r_idx) + C_ONE;
                        n_state = ST_SHIFT;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            ST_SHIFT: begin
                // read entry i, write it to i-1 once its read data returns
                if (issue) begin
                    ram_re     = 1'b1;
                    n_ptr      = r_ptr + C_ONE;
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr[IW-1:0];
                end
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pend_idx - I_ONE;
                    ram_wdata = ram_rdata;
                end
                if (walk_end) begin
                    n_total = r_total - C_ONE;
                    fin     = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // result transaction
        if (fin) begin
            n_state             = ST_IDLE;
            n_done              = 1'b1;
            n_res.found         = (r_req_type != REQ_ADD) && r_found;
            n_res.occurrences   = COUNT_W'(occ_sel);
            n_res.entry_total   = COUNT_W'(n_total);
            n_res.is_empty      = (n_total == '0);
            n_res.rejected_full = (r_req_type == REQ_ADD) && (r_total == CAP_N);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_total <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    // payload and tracking registers
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_pend_idx  <= n_pend_idx;
        r_req_type  <= n_req_type;
        r_value     <= n_value;
        r_found     <= n_found;
        r_multi     <= n_multi;
        r_first_cnt <= n_first_cnt;
        r_last_cnt  <= n_last_cnt;
        r_idx       <= n_idx;
        r_res       <= n_res;
    end

    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

    // checks
    `MCT_ASSERT_IMP(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= CAP_N, "fill count over capacity")
    `MCT_ASSERT_IMP(a_no_rw_clash, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "same entry read and written")
    `MCT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted transaction did not raise busy")
    `MCT_ASSERT_IMP(a_reject_full, i_clk, i_rst_n, o_done && o_res.rejected_full, r_total == CAP_N, "add rejected while not full")

endmodule

// File: hw/rtl/mct_ram.sv
// generic simple dual-port ram: one write port, one read port, registered read
// depends on mct_pkg only through the common import convention
module mct_ram
    import mct_pkg::*;
#(
    parameter int WIDTH = 39,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
